@@ sv/stack_packet_filter_engine_assert.svh @@
// ----------------------------------------------------------------------------
// stack_packet_filter_engine assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STACK_PACKET_FILTER_ENGINE_ASSERT_SVH
`define STACK_PACKET_FILTER_ENGINE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SPFE_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spfe assertion failed");
// next-cycle implication
`define SPFE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spfe assertion failed");
`else
`define SPFE_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define SPFE_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

@@ sv/spfe_pkg.sv @@
// ----------------------------------------------------------------------------
// spfe_pkg
// Shared types and codes of the stack packet filter engine.
// ----------------------------------------------------------------------------
`default_nettype none
package spfe_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_LIT,
        ST_PKT,
        ST_OPER,
        ST_OPB,
        ST_POP2,
        ST_RESULT
    } spfe_state_t;

    typedef enum logic [1:0] {
        PSRC_LIT,
        PSRC_ZERO,
        PSRC_PKT
    } push_src_t;

    typedef enum logic [1:0] {
        VSRC_TOS,
        VSRC_ZERO,
        VSRC_SC
    } verdict_src_t;

    localparam logic [2:0] END_PROGRAM = 3'd0;
    localparam logic [2:0] END_SHORT   = 3'd1;
    localparam logic [2:0] END_PKT     = 3'd2;
    localparam logic [2:0] END_OVER    = 3'd3;
    localparam logic [2:0] END_UNDER   = 3'd4;
    localparam logic [2:0] END_BADOP   = 3'd5;

    localparam int ACT_NONE = 0;
    localparam int ACT_LIT  = 1;
    localparam int ACT_ZERO = 2;
    localparam int ACT_WORD = 16;

    localparam int OP_NOP   = 0;
    localparam int OP_EQ    = 1;
    localparam int OP_LT    = 2;
    localparam int OP_LE    = 3;
    localparam int OP_GT    = 4;
    localparam int OP_GE    = 5;
    localparam int OP_AND   = 6;
    localparam int OP_OR    = 7;
    localparam int OP_XOR   = 8;
    localparam int OP_COR   = 9;
    localparam int OP_CAND  = 10;
    localparam int OP_CNOR  = 11;
    localparam int OP_CNAND = 12;
    localparam int OP_NEQ   = 13;

    typedef struct packed {
        logic         wr_prog;
        logic         wr_pkt;
        logic         start;
        logic         fetch;
        logic         decode;
        logic         lit_read;
        logic         pkt_read;
        logic         push;
        push_src_t    push_src;
        logic         op_read;
        logic         apply;
        logic         sc_read;
        logic         pop2;
        logic         finish;
        logic [2:0]   reason;
        verdict_src_t verdict_src;
        logic         load_out;
    } spfe_cmd_t;

    typedef struct packed {
        logic prog_done;
        logic act_none;
        logic act_lit;
        logic act_zero;
        logic act_pkt;
        logic stack_full;
        logic under;
        logic op_nop;
        logic op_bad;
        logic op_sc;
        logic sc_exit;
        logic out_free;
    } spfe_status_t;

endpackage
`default_nettype wire

@@ sv/spfe_ram.sv @@
// ----------------------------------------------------------------------------
// spfe_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module spfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

@@ sv/spfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// spfe_ctrl
// Sequencer: loads, program word fetch/decode/execute, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module spfe_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  operation,
    input  wire logic                  last,
    input  wire spfe_pkg::spfe_status_t status,
    output spfe_pkg::spfe_cmd_t        cmd,
    output logic                       in_stall
);
    import spfe_pkg::*;

    spfe_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.push_src    = PSRC_ZERO;
        cmd.verdict_src = VSRC_ZERO;
        cmd.reason      = END_PROGRAM;
        in_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (!operation)
                    begin
                        cmd.wr_prog = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_pkt = 1'b1;
                        if (last)
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                if (status.prog_done)
                begin
                    cmd.finish      = 1'b1;
                    cmd.reason      = END_PROGRAM;
                    cmd.verdict_src = VSRC_TOS;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.act_lit)
                begin
                    cmd.lit_read = 1'b1;
                    state_next   = ST_LIT;
                end
                else if (status.act_pkt)
                begin
                    cmd.pkt_read = 1'b1;
                    state_next   = ST_PKT;
                end
                else if (status.act_zero)
                begin
                    if (status.stack_full)
                    begin
                        cmd.finish = 1'b1;
                        cmd.reason = END_OVER;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        cmd.push     = 1'b1;
                        cmd.push_src = PSRC_ZERO;
                        state_next   = ST_OPER;
                    end
                end
                else if (status.act_none)
                begin
                    state_next = ST_OPER;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.reason = END_PKT;
                    state_next = ST_RESULT;
                end
            end
            ST_LIT, ST_PKT:
            begin
                if (status.stack_full)
                begin
                    cmd.finish = 1'b1;
                    cmd.reason = END_OVER;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.push_src = (state_reg == ST_LIT) ? PSRC_LIT : PSRC_PKT;
                    state_next   = ST_OPER;
                end
            end
            ST_OPER:
            begin
                if (status.op_nop)
                begin
                    state_next = ST_FETCH;
                end
                else if (status.under)
                begin
                    cmd.finish = 1'b1;
                    cmd.reason = END_UNDER;
                    state_next = ST_RESULT;
                end
                else if (status.op_bad)
                begin
                    cmd.finish = 1'b1;
                    cmd.reason = END_BADOP;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.op_read = 1'b1;
                    state_next  = ST_OPB;
                end
            end
            ST_OPB:
            begin
                if (status.op_sc)
                begin
                    if (status.sc_exit)
                    begin
                        cmd.finish      = 1'b1;
                        cmd.reason      = END_SHORT;
                        cmd.verdict_src = VSRC_SC;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        cmd.sc_read = 1'b1;
                        state_next  = ST_POP2;
                    end
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_POP2:
            begin
                cmd.pop2   = 1'b1;
                state_next = ST_FETCH;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ sv/spfe_dp.sv @@
// ----------------------------------------------------------------------------
// spfe_dp
// Datapath: program, packet and stack RAMs, top-of-stack, ALU, result reg.
// ----------------------------------------------------------------------------
`default_nettype none
module spfe_dp #(
    parameter int PROG_DEPTH   = 256,
    parameter int PACKET_WORDS = 1024,
    parameter int ARG_BITS     = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire spfe_pkg::spfe_cmd_t  cmd,
    output spfe_pkg::spfe_status_t    status,
    input  wire logic                 cfg_wr_en,
    input  wire logic [8:0]           cfg_wr_data,
    input  wire logic [9:0]           index,
    input  wire logic [15:0]          word,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic [15:0]               verdict,
    output logic                      accept,
    output logic [2:0]                end_reason
);
    import spfe_pkg::*;

    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int KAW = $clog2(PACKET_WORDS);
    localparam int PCW = $clog2(PROG_DEPTH + 2);
    localparam int DW  = $clog2(PROG_DEPTH + 1);
    localparam int LW  = $clog2(PACKET_WORDS + 1);
    localparam int OPW = 16 - ARG_BITS;

    logic [8:0]          prog_len_reg;
    logic [PCW-1:0]      pc_reg;
    logic [15:0]         ir_reg;
    logic [DW-1:0]       depth_reg;
    logic [15:0]         tos_reg;
    logic [LW-1:0]       pkt_len_reg;
    logic                lit_zero_reg;
    logic [15:0]         res_verdict_reg;
    logic [2:0]          res_reason_reg;
    logic                out_valid_reg;
    logic [15:0]         out_verdict_reg;
    logic [2:0]          out_reason_reg;

    logic [15:0]         prog_rdata, pkt_rdata, stk_rdata;
    logic [PAW-1:0]      stk_raddr;
    logic [ARG_BITS-1:0] act;
    logic [OPW-1:0]      op;
    int                  opi, acti, plen;
    logic [15:0]         push_val, alu_res, b_val;
    logic                sc_val;

    assign act  = ir_reg[ARG_BITS-1:0];
    assign op   = ir_reg[15:ARG_BITS];
    assign opi  = int'(op);
    assign acti = int'(act);
    assign plen = (int'(prog_len_reg) > PROG_DEPTH) ? PROG_DEPTH : int'(prog_len_reg);
    assign b_val = stk_rdata;

    spfe_ram #(.WIDTH(16), .DEPTH(PROG_DEPTH)) u_prog_ram (
        .clk   (clk),
        .we    (cmd.wr_prog && (int'(index) < PROG_DEPTH)),
        .waddr (PAW'(index)),
        .wdata (word),
        .re    (cmd.fetch || cmd.lit_read),
        .raddr (pc_reg[PAW-1:0]),
        .rdata (prog_rdata)
    );

    spfe_ram #(.WIDTH(16), .DEPTH(PACKET_WORDS)) u_pkt_ram (
        .clk   (clk),
        .we    (cmd.wr_pkt && (int'(index) < PACKET_WORDS)),
        .waddr (KAW'(index)),
        .wdata (word),
        .re    (cmd.pkt_read),
        .raddr (KAW'(acti - ACT_WORD)),
        .rdata (pkt_rdata)
    );

    // stack below the top-of-stack register: entry k at address k
    assign stk_raddr = cmd.sc_read ? PAW'(depth_reg - DW'(2)) : PAW'(depth_reg - DW'(1));

    spfe_ram #(.WIDTH(16), .DEPTH(PROG_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (depth_reg[PAW-1:0]),
        .wdata (tos_reg),
        .re    (cmd.op_read || cmd.sc_read),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        case (cmd.push_src)
            PSRC_LIT:  push_val = lit_zero_reg ? 16'd0 : prog_rdata;
            PSRC_PKT:  push_val = pkt_rdata;
            default:   push_val = 16'd0;
        endcase
    end

    always_comb
    begin
        case (opi)
            OP_EQ:   alu_res = {15'd0, b_val == tos_reg};
            OP_LT:   alu_res = {15'd0, b_val <  tos_reg};
            OP_LE:   alu_res = {15'd0, b_val <= tos_reg};
            OP_GT:   alu_res = {15'd0, b_val >  tos_reg};
            OP_GE:   alu_res = {15'd0, b_val >= tos_reg};
            OP_AND:  alu_res = b_val & tos_reg;
            OP_OR:   alu_res = b_val | tos_reg;
            OP_XOR:  alu_res = b_val ^ tos_reg;
            OP_NEQ:  alu_res = {15'd0, b_val != tos_reg};
            default: alu_res = 16'd0;
        endcase
    end

    assign sc_val = (opi == OP_COR) || (opi == OP_CNAND);

    always_comb
    begin
        status            = '0;
        status.prog_done  = int'(pc_reg) >= plen;
        status.act_none   = acti == ACT_NONE;
        status.act_lit    = acti == ACT_LIT;
        status.act_zero   = acti == ACT_ZERO;
        status.act_pkt    = (acti >= ACT_WORD) && ((acti - ACT_WORD) < int'(pkt_len_reg));
        status.stack_full = int'(depth_reg) >= PROG_DEPTH - 2;
        status.under      = depth_reg < DW'(2);
        status.op_nop     = opi == OP_NOP;
        status.op_bad     = opi > OP_NEQ;
        status.op_sc      = (opi >= OP_COR) && (opi <= OP_CNAND);
        status.sc_exit    = ((opi == OP_COR) || (opi == OP_CNOR)) == (b_val == tos_reg);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg  <= '0;
            pc_reg        <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prog_len_reg <= cfg_wr_data;
            end
            if (cmd.start)
            begin
                pc_reg    <= '0;
                depth_reg <= '0;
            end
            if (cmd.fetch || cmd.lit_read)
            begin
                pc_reg <= pc_reg + PCW'(1);
            end
            if (cmd.push)
            begin
                depth_reg <= depth_reg + DW'(1);
            end
            else if (cmd.apply)
            begin
                depth_reg <= depth_reg - DW'(1);
            end
            else if (cmd.pop2)
            begin
                depth_reg <= depth_reg - DW'(2);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            tos_reg     <= 16'd1;
            pkt_len_reg <= (int'(index) + 1 > PACKET_WORDS) ? LW'(PACKET_WORDS)
                                                             : LW'(int'(index) + 1);
        end
        else if (cmd.push)
        begin
            tos_reg <= push_val;
        end
        else if (cmd.apply)
        begin
            tos_reg <= alu_res;
        end
        else if (cmd.pop2)
        begin
            tos_reg <= stk_rdata;
        end
        if (cmd.decode)
        begin
            ir_reg <= prog_rdata;
        end
        if (cmd.lit_read)
        begin
            lit_zero_reg <= int'(pc_reg) >= PROG_DEPTH;
        end
        if (cmd.finish)
        begin
            res_reason_reg <= cmd.reason;
            case (cmd.verdict_src)
                VSRC_TOS: res_verdict_reg <= tos_reg;
                VSRC_SC:  res_verdict_reg <= {15'd0, sc_val};
                default:  res_verdict_reg <= 16'd0;
            endcase
        end
        if (cmd.load_out)
        begin
            out_verdict_reg <= res_verdict_reg;
            out_reason_reg  <= res_reason_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign verdict    = out_verdict_reg;
    assign accept     = out_verdict_reg != 16'd0;
    assign end_reason = out_reason_reg;
endmodule
`default_nettype wire

@@ sv/stack_packet_filter_engine.sv @@
// Load items (program or packet word) are accepted only while in_stall is low (idle).
// A packet word marked last starts evaluation: each program word steps through
// fetch, decode, execute and operator check, plus a literal/packet read and one or
// two stack RAM reads per operator; the result then goes via the result register to the output.
// Every store is a RAM with one registered read port, which sets the step count.
// Async active-low reset clears control and program_length; RAM contents undefined.
// ----------------------------------------------------------------------------
// stack_packet_filter_engine
// Stack-based packet filter evaluator top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stack_packet_filter_engine_assert.svh"
module stack_packet_filter_engine #(
    parameter int PROG_DEPTH   = 256,
    parameter int PACKET_WORDS = 1024,
    parameter int ARG_BITS     = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [9:0]  index,
    input  wire logic [15:0] word,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      verdict,
    output logic             accept,
    output logic [2:0]       end_reason
);
    import spfe_pkg::*;

    spfe_cmd_t    cmd;
    spfe_status_t status;

    spfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .last      (last),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    spfe_dp #(
        .PROG_DEPTH   (PROG_DEPTH),
        .PACKET_WORDS (PACKET_WORDS),
        .ARG_BITS     (ARG_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .index       (index),
        .word        (word),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .verdict     (verdict),
        .accept      (accept),
        .end_reason  (end_reason)
    );

    `SPFE_ASSERT_IMPL(a_accept_flag, clk, rst_n, out_valid, accept == (verdict != 16'd0))
    `SPFE_ASSERT_IMPL(a_reason_range, clk, rst_n, out_valid, end_reason <= END_BADOP)
    `SPFE_ASSERT_IMPL(a_result_after_run, clk, rst_n, $rose(out_valid), $past(in_stall))
    `SPFE_ASSERT_NEXT(a_run_stalls, clk, rst_n, in_valid && !in_stall && operation && last, in_stall)
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stack packet filter engine. Loads filter
// programs and packets, predicts each verdict with a behavioral evaluator and
// compares every result transaction field by field, under random idling.
// ----------------------------------------------------------------------------
module tb;
    import spfe_pkg::*;

    localparam int PROG_WORDS = 256;
    localparam int PKT_WORDS  = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 16;

    typedef enum bit {LOAD_PROG = 1'b0, LOAD_PKT = 1'b1} load_kind_t;

    typedef struct {
        logic [15:0] verdict;
        logic        accept;
        logic [2:0]  end_reason;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [9:0]  index;
    logic [15:0] word;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] verdict;
    logic        accept;
    logic [2:0]  end_reason;

    stack_packet_filter_engine DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .index      (index),
        .word       (word),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .verdict    (verdict),
        .accept     (accept),
        .end_reason (end_reason)
    );

    // filter model state
    logic [15:0] prog_mem [PROG_WORDS];
    logic [15:0] pkt_mem [PKT_WORDS];
    logic [8:0]  prog_len_reg;
    verdict_t    verdict_q [$];

    int snd_idle_pct;
    int rcv_idle_pct;
    int cycles;
    int fails;
    int items_sent;
    int verdicts_seen;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // filter evaluation, returns end reason
    function automatic logic [2:0] run_filter(input int pkt_len, output logic [15:0] v);
        logic [15:0] stk [PROG_WORDS + 1];
        int          pc;
        int          sp;
        int          plen;
        logic [15:0] w;
        int          op;
        int          act;
        logic [15:0] a;
        logic [15:0] b;
        pc = 0;
        sp = PROG_WORDS;
        plen = (prog_len_reg > PROG_WORDS) ? PROG_WORDS : prog_len_reg;
        stk[sp] = 16'd1;
        v = 16'd0;
        while (pc < plen)
        begin
            w = prog_mem[pc];
            op = w[15:10];
            act = w[9:0];
            pc++;
            if (act == ACT_LIT)
            begin
                sp--;
                stk[sp] = (pc < PROG_WORDS) ? prog_mem[pc] : 16'd0;
                pc++;
            end
            else if (act == ACT_ZERO)
            begin
                sp--;
                stk[sp] = 16'd0;
            end
            else if (act != ACT_NONE)
            begin
                if (act < ACT_WORD || act - ACT_WORD >= pkt_len)
                    return END_PKT;
                sp--;
                stk[sp] = pkt_mem[act - ACT_WORD];
            end
            if (sp < 2)
                return END_OVER;
            if (op == OP_NOP)
                continue;
            if (sp > PROG_WORDS - 2)
                return END_UNDER;
            a = stk[sp];
            sp++;
            b = stk[sp];
            case (op)
                OP_EQ:  stk[sp] = 16'(b == a);
                OP_LT:  stk[sp] = 16'(b < a);
                OP_LE:  stk[sp] = 16'(b <= a);
                OP_GT:  stk[sp] = 16'(b > a);
                OP_GE:  stk[sp] = 16'(b >= a);
                OP_AND: stk[sp] = b & a;
                OP_OR:  stk[sp] = b | a;
                OP_XOR: stk[sp] = b ^ a;
                OP_NEQ: stk[sp] = 16'(b != a);
                OP_COR, OP_CAND, OP_CNOR, OP_CNAND:
                begin
                    sp++;
                    if ((op == OP_COR || op == OP_CNOR) == (b == a))
                    begin
                        v = (op == OP_COR || op == OP_CNAND) ? 16'd1 : 16'd0;
                        return END_SHORT;
                    end
                end
                default: return END_BADOP;
            endcase
        end
        v = stk[sp];
        return END_PROGRAM;
    endfunction

    // model update for one accepted load transaction
    task automatic record_load(input load_kind_t k, input logic [9:0] idx,
                               input logic [15:0] w, input logic lst);
        verdict_t    e;
        logic [15:0] v;
        if (k == LOAD_PROG)
        begin
            if (idx < PROG_WORDS)
                prog_mem[idx] = w;
        end
        else
        begin
            pkt_mem[idx] = w;
            if (lst)
            begin
                e.end_reason = run_filter(int'(idx) + 1, v);
                e.verdict = v;
                e.accept = (v != 16'd0);
                verdict_q.push_back(e);
            end
        end
    endtask

    task automatic send_load(input load_kind_t k, input logic [9:0] idx,
                             input logic [15:0] w, input logic lst);
        @(negedge clk);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        operation = k;
        index = idx;
        word = w;
        last = lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        record_load(k, idx, w, lst);
        items_sent++;
    endtask

    // all results back and the engine quiet
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_length(input logic [8:0] n);
        drain();
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = n;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        prog_len_reg = n;
    endtask

    // writes words 0..n-1 plus one slot after (read by a trailing literal)
    task automatic load_program(input logic [15:0] p [$]);
        drain();
        foreach (p[i])
            send_load(LOAD_PROG, 10'(i), p[i], $urandom_range(1));
        if (p.size() < PROG_WORDS)
            send_load(LOAD_PROG, 10'(p.size()), 16'($urandom), 1'b0);
    endtask

    task automatic send_packet(input logic [15:0] d [$]);
        foreach (d[i])
            send_load(LOAD_PKT, 10'(i), d[i], i == d.size() - 1);
    endtask

    function automatic logic [15:0] pw(input int op, input int act);
        return {6'(op), 10'(act)};
    endfunction

    function automatic logic [15:0] pkt_value();
        return ($urandom_range(1)) ? 16'($urandom_range(3)) : 16'($urandom);
    endfunction

    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            verdicts_seen++;
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result transaction verdict=%h", verdict);
                fails++;
            end
            else
            begin
                e = verdict_q.pop_front();
                if (verdict !== e.verdict)
                begin
                    $error("verdict exp %h got %h", e.verdict, verdict);
                    fails++;
                end
                if (accept !== e.accept)
                begin
                    $error("accept exp %b got %b", e.accept, accept);
                    fails++;
                end
                if (end_reason !== e.end_reason)
                begin
                    $error("end_reason exp %0d got %0d", e.end_reason, end_reason);
                    fails++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [15:0] p [$];
        // empty program keeps the initial 1
        set_length(9'd0);
        send_packet('{16'h0000});
        // literal compare against packet word
        p = '{pw(OP_NOP, ACT_LIT), 16'hFFFF, pw(OP_EQ, ACT_WORD)};
        load_program(p);
        set_length(9'd3);
        send_packet('{16'hFFFF});
        send_packet('{16'hFFFE, 16'h1234});
        // short circuit: cor on equal
        load_program('{pw(OP_NOP, ACT_ZERO), pw(OP_COR, ACT_WORD)});
        set_length(9'd2);
        send_packet('{16'h0000});
        // packet word past the length, and a reserved push code
        load_program('{pw(OP_NOP, ACT_WORD + 5), pw(OP_NOP, 3)});
        set_length(9'd1);
        send_packet('{16'h0001});
        set_length(9'd2);
        send_packet('{16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
        // underflow; the bad operator word after it lies past the program length
        load_program('{pw(OP_AND, ACT_NONE), pw(14, ACT_ZERO)});
        set_length(9'd1);
        send_packet('{16'h5555});
        // literal past program end
        load_program('{pw(OP_NOP, ACT_LIT)});
        send_load(LOAD_PROG, 10'd1, 16'hA5C3, 1'b0);
        set_length(9'd1);
        send_packet('{16'h0});
        // ignored program writes above the store
        send_load(LOAD_PROG, 10'd300, 16'hFFFF, 1'b1);
        send_load(LOAD_PROG, 10'd1023, 16'hFFFF, 1'b0);
        send_packet('{16'h1});
    endtask

    // full-depth program of zero pushes: deepest legal stack, overflow, saturated length
    task automatic test_stack_limits();
        logic [15:0] p [$];
        p = {};
        for (int i = 0; i < PROG_WORDS; i++)
            p.push_back(pw(OP_NOP, ACT_ZERO));
        load_program(p);
        set_length(9'd254);
        send_packet('{16'h0});
        set_length(9'd256);
        send_packet('{16'h0});
        set_length(9'd511);
        send_packet('{16'h0});
    endtask

    // longest packet: only the words the program reads are written
    task automatic test_full_packet();
        load_program('{pw(OP_NOP, ACT_WORD + 1023), pw(OP_XOR, ACT_WORD)});
        set_length(9'd2);
        send_load(LOAD_PKT, 10'd0, 16'($urandom), 1'b0);
        send_load(LOAD_PKT, 10'd1023, 16'($urandom), 1'b1);
    endtask

    task automatic random_program(output logic [15:0] p [$], input int max_pkt);
        int n;
        int r;
        int act;
        int op;
        p = {};
        n = $urandom_range(1, 12);
        while (p.size() < n)
        begin
            r = $urandom_range(99);
            if (r < 12)
                act = ACT_NONE;
            else if (r < 32)
                act = ACT_LIT;
            else if (r < 42)
                act = ACT_ZERO;
            else if (r < 95)
                act = ACT_WORD + $urandom_range(max_pkt);
            else
                act = (r == 99) ? $urandom_range(1023) : $urandom_range(3, 15);
            r = $urandom_range(99);
            if (p.size() < 2 || r < 15)
                op = OP_NOP;
            else if (r < 95)
                op = $urandom_range(1, 13);
            else
                op = $urandom_range(14, 63);
            p.push_back(pw(op, act));
            if (act == ACT_LIT)
                p.push_back(pkt_value());
        end
    endtask

    task automatic test_random(input int target);
        logic [15:0] p [$];
        logic [15:0] d [$];
        int start;
        int plen;
        start = items_sent;
        while (items_sent - start < target)
        begin
            random_program(p, 8);
            load_program(p);
            set_length(9'(p.size() - $urandom_range(1) * (p.size() > 1)));
            repeat ($urandom_range(2, 5))
            begin
                plen = $urandom_range(1, 8);
                d = {};
                for (int i = 0; i < plen; i++)
                    d.push_back(pkt_value());
                if ($urandom_range(9) == 0)
                    send_load(LOAD_PKT, 10'($urandom_range(plen)), pkt_value(), 1'b0);
                send_packet(d);
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        operation = LOAD_PROG;
        index = '0;
        word = '0;
        last = 1'b0;
        out_stall = 1'b0;
        prog_len_reg = '0;
        cycles = 0;
        fails = 0;
        items_sent = 0;
        verdicts_seen = 0;
        snd_idle_pct = 33;
        rcv_idle_pct = 87;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_stack_limits();
        test_full_packet();
        test_random(35);
        snd_idle_pct = 87;
        rcv_idle_pct = 33;
        test_random(35);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(35);

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d load transactions and %0d filter verdicts", items_sent,
                 verdicts_seen);
        $display("directed edge cases, full-depth programs, max packet, random programs");
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
